// File: rtl/core/wf3_pkg.sv
// Shared types and constants of the 3x3 window filter stream.
// Payload structs, register indexes, mode codes and divide-by-nine constants.
// No dependencies.
package wf3_pkg;

  // Pixel and configuration field widths
  localparam int unsigned PIXEL_BITS     = 8;
  localparam int unsigned WIDTH_BITS     = 12;
  localparam int unsigned HEIGHT_BITS    = 13;
  localparam int unsigned MODE_BITS      = 2;
  localparam int unsigned CFG_INDEX_BITS = 2;
  localparam int unsigned CFG_DATA_BITS  = 13;
  localparam int unsigned ROW_BITS       = HEIGHT_BITS + 1;
  localparam int unsigned MIN_DIM        = 3;
  localparam int unsigned QUEUE_DEPTH    = 4;

  // Register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FILTER_MODE  = 2'd2;

  // Register reset values
  localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 12'd640;
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 13'd480;

  // Filter modes; the unused code behaves as box blur
  localparam logic [MODE_BITS-1:0] MODE_BLUR     = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_HIGHPASS = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_SHARPEN  = 2'd2;

  // Item kinds
  localparam logic FUNC_FLUSH = 1'b1;

  // Window sum and divide by nine through a reciprocal multiply
  localparam int unsigned SUM_BITS       = PIXEL_BITS + 4;
  localparam int unsigned DIV9_SHIFT     = SUM_BITS + 7;
  localparam int unsigned DIV9_MUL_BITS  = DIV9_SHIFT - 2;
  localparam int unsigned DIV9_PROD_BITS = SUM_BITS + 1 + DIV9_MUL_BITS;
  localparam logic [DIV9_MUL_BITS-1:0] DIV9_MUL =
    DIV9_MUL_BITS'(((64'd1 << DIV9_SHIFT) + 64'd8) / 64'd9);

  localparam logic [PIXEL_BITS-1:0] PIX_MAX = {PIXEL_BITS{1'b1}};

  typedef struct packed {
    logic                  func;
    logic [PIXEL_BITS-1:0] pixel;
  } wf3_in_t;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] out_pixel;
    logic                  frame_end;
  } wf3_out_t;

  // Per-advance control carried from front to back
  typedef struct packed {
    logic emit;       // this advance produces a result
    logic border;     // result position lies on the frame border
    logic frame_end;  // result is the last of the frame
    logic bank;       // line-store bank that takes the new pixel
  } wf3_ctl_t;

endpackage

// File: rtl/core/wf3_front.sv
// Front end of the window filter: configuration registers, raster counters
// and item classification. Depends on wf3_pkg.
module wf3_front #(
  parameter int unsigned MAX_WIDTH = 2048,
  localparam int unsigned COL_BITS = $clog2(MAX_WIDTH)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [wf3_pkg::CFG_INDEX_BITS-1:0]  cfg_index_i,
  input  logic [wf3_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  wf3_pkg::wf3_in_t                    in_data_i,
  output logic                                push_o,
  input  logic                                push_ready_i,
  output wf3_pkg::wf3_ctl_t                   push_ctl_o,
  output logic [wf3_pkg::PIXEL_BITS-1:0]      push_pixel_o,
  output logic [COL_BITS-1:0]                 push_col_o,
  output logic [wf3_pkg::MODE_BITS-1:0]       mode_o
);
  import wf3_pkg::*;

  localparam int unsigned WW        = $clog2(MAX_WIDTH + 1);
  localparam int unsigned LEAD_BITS = $clog2(MAX_WIDTH + 2);
  localparam int unsigned CMP_BITS  = (WW > WIDTH_BITS) ? WW : WIDTH_BITS;

  logic [WIDTH_BITS-1:0]  width_q, width_d;
  logic [HEIGHT_BITS-1:0] height_q, height_d;
  logic [MODE_BITS-1:0]   mode_q, mode_d;
  logic [COL_BITS-1:0]    in_col_q, in_col_d;
  logic [ROW_BITS-1:0]    in_row_q, in_row_d;
  logic [COL_BITS-1:0]    out_col_q, out_col_d;
  logic [HEIGHT_BITS-1:0] out_row_q, out_row_d;
  logic [LEAD_BITS-1:0]   lead_q, lead_d;

  logic [CMP_BITS-1:0]    fw_ext;
  logic [WW-1:0]          w_eff;
  logic [HEIGHT_BITS-1:0] h_eff;
  logic                   accept, frame_in, adv, emit;
  logic                   col_last, ocol_last, orow_last, border, fend;
  logic                   restart;

  // Clamp the geometry registers
  always_comb begin
    fw_ext = CMP_BITS'(width_q);
    if (fw_ext < CMP_BITS'(MIN_DIM)) begin
      w_eff = WW'(MIN_DIM);
    end else if (fw_ext > CMP_BITS'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(fw_ext);
    end
    h_eff = (height_q < HEIGHT_BITS'(MIN_DIM)) ? HEIGHT_BITS'(MIN_DIM) : height_q;
  end

  // Classify the item: once all pixels are in, every item drains one position
  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && push_ready_i;
  assign frame_in   = in_row_q >= ROW_BITS'(h_eff);
  assign adv        = accept && (frame_in || (in_data_i.func != FUNC_FLUSH));
  assign emit       = lead_q == (LEAD_BITS'(w_eff) + LEAD_BITS'(1));

  // Output position flags
  assign col_last  = WW'(in_col_q) == (w_eff - WW'(1));
  assign ocol_last = WW'(out_col_q) == (w_eff - WW'(1));
  assign orow_last = out_row_q == (h_eff - HEIGHT_BITS'(1));
  assign border    = (out_row_q == '0) || orow_last || (out_col_q == '0) || ocol_last;
  assign fend      = orow_last && ocol_last;

  // Advance counters and take configuration writes
  always_comb begin
    width_d   = width_q;
    height_d  = height_q;
    mode_d    = mode_q;
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    lead_d    = lead_q;
    restart   = 1'b0;

    if (adv) begin
      if (col_last) begin
        in_col_d = '0;
        in_row_d = in_row_q + ROW_BITS'(1);
      end else begin
        in_col_d = in_col_q + COL_BITS'(1);
      end
      if (!emit) begin
        lead_d = lead_q + LEAD_BITS'(1);
      end else if (fend) begin
        restart = 1'b1;
      end else if (ocol_last) begin
        out_col_d = '0;
        out_row_d = out_row_q + HEIGHT_BITS'(1);
      end else begin
        out_col_d = out_col_q + COL_BITS'(1);
      end
    end

    if (cfg_we_i) begin
      case (cfg_index_i)
        REG_FRAME_WIDTH: begin
          width_d = cfg_data_i[WIDTH_BITS-1:0];
          restart = 1'b1;
        end
        REG_FRAME_HEIGHT: begin
          height_d = cfg_data_i[HEIGHT_BITS-1:0];
          restart  = 1'b1;
        end
        REG_FILTER_MODE: begin
          mode_d = cfg_data_i[MODE_BITS-1:0];
        end
        default: begin
        end
      endcase
    end

    if (restart) begin
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
      lead_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= WIDTH_RESET;
      height_q  <= HEIGHT_RESET;
      mode_q    <= MODE_BLUR;
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      lead_q    <= '0;
    end else begin
      width_q   <= width_d;
      height_q  <= height_d;
      mode_q    <= mode_d;
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      lead_q    <= lead_d;
    end
  end

  // Hand the advance to the queue
  always_comb begin
    push_o               = adv;
    push_ctl_o.emit      = emit;
    push_ctl_o.border    = border;
    push_ctl_o.frame_end = fend;
    push_ctl_o.bank      = in_row_q[0];
    push_pixel_o         = frame_in ? '0 : in_data_i.pixel;
    push_col_o           = in_col_q;
    mode_o               = mode_q;
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && push_ctl_o.frame_end |-> push_ctl_o.emit && push_ctl_o.border)
    else $error("frame end flagged on a non-border or non-emitting advance");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && push_ctl_o.emit && push_ctl_o.frame_end
      |=> in_row_q == '0 && lead_q == '0 && out_row_q == '0 && in_col_q == '0)
    else $error("counters not restarted after the last result of a frame");
`endif

endmodule

// File: rtl/core/wf3_queue.sv
// Short FIFO between the front end and the filter back end.
// Generic payload vector; depends on nothing.
module wf3_queue #(
  parameter int unsigned DATA_BITS = 24,
  parameter int unsigned DEPTH     = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  output logic                 ready_o,
  input  logic [DATA_BITS-1:0] data_i,
  output logic                 valid_o,
  input  logic                 pop_i,
  output logic [DATA_BITS-1:0] data_o
);

  localparam int unsigned PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);

  logic [DATA_BITS-1:0] store_q [DEPTH];
  logic [PTR_BITS-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_BITS-1:0]  count_q;
  logic                 push_ok, pop_ok;

  assign ready_o = count_q != CNT_BITS'(DEPTH);
  assign valid_o = count_q != '0;
  assign push_ok = push_i && ready_o;
  assign pop_ok  = pop_i && valid_o;
  assign data_o  = store_q[rd_ptr_q];

  // Write the entry
  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      store_q[wr_ptr_q] <= data_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr_q <= (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_BITS'(1);
      end
      if (pop_ok) begin
        rd_ptr_q <= (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_BITS'(1);
      end
      if (push_ok && !pop_ok) begin
        count_q <= count_q + CNT_BITS'(1);
      end else if (pop_ok && !push_ok) begin
        count_q <= count_q - CNT_BITS'(1);
      end
    end
  end

endmodule

// File: rtl/core/wf3_back.sv
// Back end of the window filter: line store, 3x3 window, sum, divide by nine,
// mode select and output register. Depends on wf3_pkg.
module wf3_back #(
  parameter int unsigned MAX_WIDTH = 2048,
  localparam int unsigned COL_BITS = $clog2(MAX_WIDTH)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           q_valid_i,
  output logic                           q_pop_o,
  input  wf3_pkg::wf3_ctl_t              q_ctl_i,
  input  logic [wf3_pkg::PIXEL_BITS-1:0] q_pixel_i,
  input  logic [COL_BITS-1:0]            q_col_i,
  input  logic [wf3_pkg::MODE_BITS-1:0]  mode_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output wf3_pkg::wf3_out_t              out_data_o
);
  import wf3_pkg::*;

  localparam int unsigned DIFF_BITS = PIXEL_BITS + 5;

  logic adv;

  // Line store, one bank per row parity
  logic [PIXEL_BITS-1:0] bank0_mem [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] bank1_mem [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] rd0_q, rd1_q;

  // Stage registers
  logic                  s1_valid_q;
  wf3_ctl_t              s1_ctl_q;
  logic [PIXEL_BITS-1:0] s1_pixel_q;
  logic [PIXEL_BITS-1:0] win_q [3][3];   // [column][row], column 2 newest
  logic                  s2_valid_q, s2_border_q, s2_fend_q;
  logic [SUM_BITS-1:0]   col_sum [3];
  logic [SUM_BITS-1:0]   sum_d, sum_q;
  logic [PIXEL_BITS-1:0] s3_center_q;
  logic                  s3_valid_q, s3_border_q, s3_fend_q;
  logic [DIV9_PROD_BITS-1:0] prod;
  logic [SUM_BITS-1:0]       ten_c;
  logic signed [DIFF_BITS-1:0] diff;
  logic [PIXEL_BITS-1:0] blur_d, sharp_d;
  logic [PIXEL_BITS-1:0] blur_q, sharp_q, s4_center_q;
  logic                  s4_valid_q, s4_fend_q;
  logic [PIXEL_BITS-1:0] result;
  logic                  out_valid_q;
  wf3_out_t              out_data_q;

  // Move the whole pipeline unless the output holds an untaken result
  assign adv         = !out_valid_q || out_ready_i;
  assign q_pop_o     = q_valid_i && adv;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Read both banks at the column, write the new pixel into its bank
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      if (!q_ctl_i.bank) begin
        bank0_mem[q_col_i] <= q_pixel_i;
      end
      rd0_q <= bank0_mem[q_col_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      if (q_ctl_i.bank) begin
        bank1_mem[q_col_i] <= q_pixel_i;
      end
      rd1_q <= bank1_mem[q_col_i];
    end
  end

  // Stage 1: hold the popped entry beside the memory read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= q_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      s1_ctl_q   <= q_ctl_i;
      s1_pixel_q <= q_pixel_i;
    end
  end

  // Stage 2: shift the window by one column
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          win_q[c][r] <= '0;
        end
      end
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s2_valid_q <= s1_valid_q && s1_ctl_q.emit;
      if (s1_valid_q) begin
        win_q[0]    <= win_q[1];
        win_q[1]    <= win_q[2];
        win_q[2][0] <= s1_ctl_q.bank ? rd1_q : rd0_q;
        win_q[2][1] <= s1_ctl_q.bank ? rd0_q : rd1_q;
        win_q[2][2] <= s1_pixel_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_border_q <= s1_ctl_q.border;
      s2_fend_q   <= s1_ctl_q.frame_end;
    end
  end

  // Stage 3: sum the nine window pixels
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      col_sum[c] = SUM_BITS'(win_q[c][0]) + SUM_BITS'(win_q[c][1]) + SUM_BITS'(win_q[c][2]);
    end
    sum_d = col_sum[0] + col_sum[1] + col_sum[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (adv) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sum_q       <= sum_d;
      s3_center_q <= win_q[1][1];
      s3_border_q <= s2_border_q;
      s3_fend_q   <= s2_fend_q;
    end
  end

  // Stage 4: rounded blur through the reciprocal, clamped sharpen
  always_comb begin
    prod   = DIV9_PROD_BITS'(sum_q + SUM_BITS'(4)) * DIV9_PROD_BITS'(DIV9_MUL);
    blur_d = s3_border_q ? '0 : prod[DIV9_SHIFT +: PIXEL_BITS];
    ten_c  = SUM_BITS'({s3_center_q, 3'b000}) + SUM_BITS'({s3_center_q, 1'b0});
    diff   = $signed({1'b0, ten_c}) - $signed({1'b0, sum_q});
    if (s3_border_q || diff < 0) begin
      sharp_d = '0;
    end else if (diff > $signed(DIFF_BITS'(PIX_MAX))) begin
      sharp_d = PIX_MAX;
    end else begin
      sharp_d = diff[PIXEL_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
    end else if (adv) begin
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      blur_q      <= blur_d;
      sharp_q     <= sharp_d;
      s4_center_q <= s3_center_q;
      s4_fend_q   <= s3_fend_q;
    end
  end

  // Select by mode into the output register
  always_comb begin
    case (mode_i)
      MODE_HIGHPASS: result = (s4_center_q > blur_q) ? (s4_center_q - blur_q) : '0;
      MODE_SHARPEN:  result = sharp_q;
      default:       result = blur_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s4_valid_q) begin
      out_data_q.out_pixel <= result;
      out_data_q.frame_end <= s4_fend_q;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(s1_valid_q) && $stable(s3_valid_q) && $stable(s4_valid_q))
    else $error("pipeline moved while the output was stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s4_valid_q && adv |=> out_valid_q)
    else $error("finished result did not reach the output register");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |=> $stable(win_q[1][1]) && $stable(win_q[2][2]))
    else $error("window shifted without a line-store read");
`endif

endmodule

// File: rtl/core/window_filter_3x3_stream.sv
// Streaming 3x3 window filter (box blur, high pass, sharpen) over gray pixels.
// Top level; depends on wf3_pkg, wf3_front, wf3_queue and wf3_back.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_data_i) carries pixel items
//   in raster order, or flush items once a frame's pixels are all in. Output
//   channel (out_valid_o / out_ready_i / out_data_o) returns filtered pixels
//   in raster order; frame_end marks the last one of a frame.
//   Configuration: cfg_we_i writes cfg_data_i into the register at
//   cfg_index_i (0 frame width, 1 frame height, 2 filter mode).
//   A geometry write restarts the frame; write only while the block is idle.
// Throughput: one item per cycle while the queue has room. Each item makes one
//   read of both line-store banks and one write at its column, which sets that figure.
// Results: the result for a raster position reaches the output register through the
//   queue and the stage registers after the transfer of the item that lies width + 1
//   positions later; the last width + 1 results of a frame are drained by flush items.
// Reset: registers return to width 640, height 480, box blur; counters and
//   window clear. No clearing pass over the line store is needed.
// Stall: while the output waits, a 4-entry queue keeps taking items and
//   in_ready_o drops only when it is full.
module window_filter_3x3_stream #(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [wf3_pkg::CFG_INDEX_BITS-1:0]  cfg_index_i,
  input  logic [wf3_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  wf3_pkg::wf3_in_t                    in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output wf3_pkg::wf3_out_t                   out_data_o
);
  import wf3_pkg::*;

  localparam int unsigned COL_BITS = $clog2(MAX_WIDTH);
  localparam int unsigned Q_BITS   = $bits(wf3_ctl_t) + PIXEL_BITS + COL_BITS;

  logic                  push, push_ready;
  wf3_ctl_t              push_ctl, q_ctl;
  logic [PIXEL_BITS-1:0] push_pixel, q_pixel;
  logic [COL_BITS-1:0]   push_col, q_col;
  logic [Q_BITS-1:0]     q_in, q_out;
  logic                  q_valid, q_pop;
  logic [MODE_BITS-1:0]  mode;

  wf3_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .push_o       (push),
    .push_ready_i (push_ready),
    .push_ctl_o   (push_ctl),
    .push_pixel_o (push_pixel),
    .push_col_o   (push_col),
    .mode_o       (mode)
  );

  // Pack and unpack the queue entry
  assign q_in = {push_ctl, push_pixel, push_col};
  assign {q_ctl, q_pixel, q_col} = q_out;

  wf3_queue #(
    .DATA_BITS (Q_BITS),
    .DEPTH     (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .ready_o (push_ready),
    .data_i  (q_in),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .data_o  (q_out)
  );

  wf3_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_ctl_i     (q_ctl),
    .q_pixel_i   (q_pixel),
    .q_col_i     (q_col),
    .mode_i      (mode),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: sim/tb_window_filter_3x3_stream.sv
// Self-checking testbench for window_filter_3x3_stream: a bit-exact model of the
// line buffers and 3x3 window predicts each filtered pixel and checks it in order.
// Depends on wf3_pkg and the window_filter_3x3_stream RTL.
`timescale 1ns / 100ps

module tb_window_filter_3x3_stream;
  import wf3_pkg::*;

  localparam int unsigned LINE_MAX      = 2048;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned STALL_LIMIT   = 4000;
  localparam int unsigned RANDOM_ITEMS  = 420;
  localparam int unsigned WIDE_ITEMS    = 300;
  localparam int unsigned HOLD_CYCLES   = 400;

  localparam logic                      FUNC_PIXEL  = 1'b0;
  localparam logic [MODE_BITS-1:0]      MODE_UNUSED = 2'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED  = 2'd3;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [CFG_INDEX_BITS-1:0] cfg_index_i;
  logic [CFG_DATA_BITS-1:0]  cfg_data_i;
  logic                      in_valid_i;
  logic                      in_ready_o;
  wf3_in_t                   in_data_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  wf3_out_t                  out_data_o;

  window_filter_3x3_stream DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Filter model state: line banks by row parity, window [column][row], counters
  logic [PIXEL_BITS-1:0]  line_mem [0:2*LINE_MAX-1];
  logic [PIXEL_BITS-1:0]  win [0:2][0:2];
  int unsigned            col_pos, row_pos, out_idx;
  logic [WIDTH_BITS-1:0]  width_reg;
  logic [HEIGHT_BITS-1:0] height_reg;
  logic [MODE_BITS-1:0]   mode_reg;

  wf3_out_t    expected_pixels [$];
  int unsigned items_in, ignored_items, results_seen, frames_done, error_count;
  int unsigned stall_cycles;
  int          hold_left;
  bit          tx_gaps, rx_gaps;

  // ---------------------------------------------------------------- model

  function automatic int unsigned eff_w();
    if (width_reg < MIN_DIM) return MIN_DIM;
    if (width_reg > LINE_MAX) return LINE_MAX;
    return 32'(width_reg);
  endfunction

  function automatic int unsigned eff_h();
    if (height_reg < MIN_DIM) return MIN_DIM;
    return 32'(height_reg);
  endfunction

  function automatic logic [PIXEL_BITS-1:0] filter_pixel(input int unsigned orow,
      input int unsigned ocol, input int unsigned w, input int unsigned h);
    int unsigned sum, center, blur;
    int          sharp;
    bit          border;
    sum = 0;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        sum += 32'(win[i][j]);
    center = 32'(win[1][1]);
    border = (orow == 0) || (orow == h - 1) || (ocol == 0) || (ocol == w - 1);
    blur   = border ? 0 : (sum + 4) / 9;
    case (mode_reg)
      MODE_HIGHPASS: return (center > blur) ? PIXEL_BITS'(center - blur) : '0;
      MODE_SHARPEN: begin
        if (border) return '0;
        sharp = 10 * int'(center) - int'(sum);
        if (sharp < 0) sharp = 0;
        if (sharp > int'(PIX_MAX)) sharp = int'(PIX_MAX);
        return PIXEL_BITS'(sharp);
      end
      default: return PIXEL_BITS'(blur);
    endcase
  endfunction

  // Shift one pixel (real or virtual) into the window; queue a result when due
  function automatic void advance_window(input logic [PIXEL_BITS-1:0] pix);
    int unsigned w, h, x, r, new_addr, old_addr, n;
    wf3_out_t    res;
    w = eff_w();
    h = eff_h();
    x = col_pos;
    r = row_pos;
    new_addr = (r % 2) * LINE_MAX + x;
    old_addr = ((r + 1) % 2) * LINE_MAX + x;
    for (int i = 0; i < 3; i++) begin
      win[0][i] = win[1][i];
      win[1][i] = win[2][i];
    end
    win[2][0] = line_mem[new_addr];
    win[2][1] = line_mem[old_addr];
    win[2][2] = pix;
    line_mem[new_addr] = pix;
    n = r * w + x;
    col_pos = x + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = r + 1;
    end
    if (n < w + 1) return;
    res.out_pixel = filter_pixel(out_idx / w, out_idx % w, w, h);
    res.frame_end = 1'b0;
    out_idx++;
    if (out_idx >= w * h) begin
      res.frame_end = 1'b1;
      row_pos = 0;
      col_pos = 0;
      out_idx = 0;
    end
    expected_pixels.push_back(res);
  endfunction

  // Once the frame is in, every item drains; before that a flush does nothing
  function automatic void predict_item(input wf3_in_t item);
    if (row_pos >= eff_h()) advance_window('0);
    else if (item.func != FUNC_FLUSH) advance_window(item.pixel);
  endfunction

  function automatic int unsigned pixels_due();
    if (row_pos >= eff_h()) return 0;
    return eff_w() * eff_h() - (row_pos * eff_w() + col_pos);
  endfunction

  function automatic int unsigned results_due();
    return eff_w() * eff_h() - out_idx;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  function automatic wf3_in_t make_item(input logic func, input logic [PIXEL_BITS-1:0] pix);
    wf3_in_t item;
    item.func  = func;
    item.pixel = pix;
    return item;
  endfunction

  // Favor the two extremes so clamps and saturation show up often
  function automatic logic [PIXEL_BITS-1:0] pick_pixel();
    logic [PIXEL_BITS-1:0] v;
    v = PIXEL_BITS'($urandom_range(255));
    case ($urandom_range(9))
      0: v = '0;
      1: v = PIX_MAX;
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [CFG_DATA_BITS-1:0] rand_dim(input int unsigned lo,
      input int unsigned hi);
    if ($urandom_range(9) == 0) return CFG_DATA_BITS'($urandom_range(2));
    return CFG_DATA_BITS'($urandom_range(hi, lo));
  endfunction

  // Offer one item; valid stays up until the transfer, then the model takes it
  task automatic send_item(input wf3_in_t item);
    while (tx_gaps && $urandom_range(99) < 9) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    if (row_pos < eff_h() && item.func == FUNC_FLUSH) ignored_items++;
    else items_in++;
    predict_item(item);
  endtask

  // Pixel items, with an occasional flush that must be ignored mid-frame
  task automatic send_pixels(input int unsigned count);
    repeat (count) begin
      if ($urandom_range(99) < 3)
        send_item(make_item(FUNC_FLUSH, PIXEL_BITS'($urandom_range(255))));
      send_item(make_item(FUNC_PIXEL, pick_pixel()));
    end
  endtask

  // Drain with a mix of flush items and pixel items that act as flushes
  task automatic drain_frame(input int unsigned count);
    repeat (count)
      send_item(make_item(logic'($urandom_range(1)), PIXEL_BITS'($urandom_range(255))));
  endtask

  // Drop valid, wait for every expected result, then let the pipeline empty
  task automatic settle_output();
    in_valid_i <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
      input logic [CFG_DATA_BITS-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    case (idx)
      REG_FRAME_WIDTH:  width_reg  = val[WIDTH_BITS-1:0];
      REG_FRAME_HEIGHT: height_reg = val[HEIGHT_BITS-1:0];
      REG_FILTER_MODE:  mode_reg   = val[MODE_BITS-1:0];
      default: ;
    endcase
    // Geometry writes restart the frame
    if (idx == REG_FRAME_WIDTH || idx == REG_FRAME_HEIGHT) begin
      row_pos = 0;
      col_pos = 0;
      out_idx = 0;
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------- tests

  // Reset geometry yields nothing early; then a 3x3 sharpen frame with flush cases
  task automatic test_smallest_frame();
    logic [PIXEL_BITS-1:0] spot [9];
    spot = '{8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00};
    repeat (6) send_item(make_item(FUNC_PIXEL, pick_pixel()));
    settle_output();
    write_reg(REG_FRAME_WIDTH, 13'd3);
    write_reg(REG_FRAME_HEIGHT, 13'd3);
    write_reg(REG_FILTER_MODE, CFG_DATA_BITS'(MODE_SHARPEN));
    // flush with pixels still due: no effect
    send_item(make_item(FUNC_FLUSH, 8'hFF));
    foreach (spot[k]) send_item(make_item(FUNC_PIXEL, spot[k]));
    send_item(make_item(FUNC_FLUSH, 8'h00));
    send_item(make_item(FUNC_PIXEL, 8'hAA));
    send_item(make_item(FUNC_FLUSH, 8'h00));
    send_item(make_item(FUNC_PIXEL, 8'h55));
    // after the frame end there is nothing to drain
    send_item(make_item(FUNC_FLUSH, 8'h00));
    settle_output();
  endtask

  // Out-of-range register values clamp; the unused index and mode code are harmless
  task automatic test_register_limits();
    logic [PIXEL_BITS-1:0] spot [9];
    spot = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    write_reg(REG_FRAME_WIDTH, 13'h1000);
    write_reg(REG_FRAME_HEIGHT, 13'd1);
    write_reg(REG_FILTER_MODE, CFG_DATA_BITS'(MODE_UNUSED));
    write_reg(REG_UNUSED, 13'h1FFF);
    foreach (spot[k]) send_item(make_item(FUNC_PIXEL, spot[k]));
    repeat (4) send_item(make_item(FUNC_PIXEL, PIXEL_BITS'($urandom_range(255))));
    settle_output();
  endtask

  // Geometry write mid-frame restarts it; a mode write mid-frame does not
  task automatic test_restart();
    write_reg(REG_FRAME_WIDTH, 13'd5);
    write_reg(REG_FRAME_HEIGHT, 13'd4);
    write_reg(REG_FILTER_MODE, CFG_DATA_BITS'(MODE_HIGHPASS));
    send_pixels(9);
    settle_output();
    write_reg(REG_FRAME_HEIGHT, 13'd4);
    send_pixels(10);
    settle_output();
    write_reg(REG_FILTER_MODE, CFG_DATA_BITS'(MODE_SHARPEN));
    send_pixels(pixels_due());
    drain_frame(results_due());
    settle_output();
  endtask

  // Hold the output off long enough that the block stalls its input
  task automatic test_backpressure();
    write_reg(REG_FRAME_WIDTH, 13'd8);
    write_reg(REG_FRAME_HEIGHT, 13'd6);
    write_reg(REG_FILTER_MODE, CFG_DATA_BITS'(MODE_BLUR));
    hold_left = HOLD_CYCLES;
    send_pixels(pixels_due());
    drain_frame(results_due());
    settle_output();
  endtask

  // Mostly small random frames; some partial, some reconfigured, some back to back
  task automatic test_random_frames();
    int unsigned start, choice, due;
    start = items_in;
    while (items_in - start < RANDOM_ITEMS) begin
      choice = $urandom_range(99);
      if (choice < 30) begin
        settle_output();
        write_reg(REG_FRAME_WIDTH, rand_dim(3, 12));
        write_reg(REG_FRAME_HEIGHT, rand_dim(3, 8));
        write_reg(REG_FILTER_MODE, CFG_DATA_BITS'($urandom_range(3)));
      end else if (choice < 45) begin
        settle_output();
        write_reg(REG_FILTER_MODE, CFG_DATA_BITS'($urandom_range(3)));
      end
      due = pixels_due();
      if (due > 1 && $urandom_range(99) < 15) due = $urandom_range(due - 1, 1);
      send_pixels(due);
      if (row_pos >= eff_h()) drain_frame(results_due());
    end
    settle_output();
  endtask

  // Width field all ones clamps to the widest line: a partial row gives nothing.
  // Then a full frame back to back; no random gaps on either side in this stretch.
  task automatic test_widest_frame();
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    write_reg(REG_FRAME_WIDTH, 13'hFFF);
    write_reg(REG_FRAME_HEIGHT, 13'd3);
    write_reg(REG_FILTER_MODE, CFG_DATA_BITS'(MODE_HIGHPASS));
    send_pixels(WIDE_ITEMS);
    settle_output();
    write_reg(REG_FRAME_WIDTH, 13'd12);
    write_reg(REG_FRAME_HEIGHT, 13'd8);
    send_pixels(pixels_due());
    drain_frame(results_due());
    settle_output();
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
  endtask

  // Tallest frame, only the top rows of it
  task automatic test_tallest_frame();
    write_reg(REG_FRAME_WIDTH, 13'd3);
    write_reg(REG_FRAME_HEIGHT, 13'h1FFF);
    write_reg(REG_FILTER_MODE, CFG_DATA_BITS'(MODE_BLUR));
    send_pixels(90);
    settle_output();
  endtask

  // ---------------------------------------------------------------- processes

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: random stalls, or a counted hold-off when a test asks for one
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= !(rx_gaps && $urandom_range(99) < 9);
      end
    end
  end

  // Compare each output transfer with the oldest expected pixel
  always @(posedge clk_i) begin : check_results
    wf3_out_t want;
    if (out_valid_o && out_ready_i) begin
      results_seen++;
      if (out_data_o.frame_end === 1'b1) frames_done++;
      if (expected_pixels.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected result %0d: pixel %0d end %0b", results_seen,
                   out_data_o.out_pixel, out_data_o.frame_end);
      end else begin
        want = expected_pixels.pop_front();
        if (out_data_o.out_pixel !== want.out_pixel ||
            out_data_o.frame_end !== want.frame_end) begin
          error_count++;
          if (error_count <= 10)
            $display("mismatch at result %0d: expected pixel %0d end %0b, got %0d end %0b",
                     results_seen, want.out_pixel, want.frame_end,
                     out_data_o.out_pixel, out_data_o.frame_end);
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
               stall_cycles, expected_pixels.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    tx_gaps       = 1'b1;
    rx_gaps       = 1'b1;
    hold_left     = 0;
    stall_cycles  = 0;
    items_in      = 0;
    ignored_items = 0;
    results_seen  = 0;
    frames_done   = 0;
    error_count   = 0;
    // model reset: registers to their defaults, window and counters clear
    width_reg  = WIDTH_RESET;
    height_reg = HEIGHT_RESET;
    mode_reg   = MODE_BLUR;
    row_pos    = 0;
    col_pos    = 0;
    out_idx    = 0;
    foreach (line_mem[a]) line_mem[a] = '0;
    foreach (win[c, r]) win[c][r] = '0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_smallest_frame();
    test_register_limits();
    test_restart();
    test_backpressure();
    test_random_frames();
    test_widest_frame();
    test_tallest_frame();
    settle_output();

    $display("covered %0d items (%0d ignored flushes), %0d results checked, %0d frames",
             items_in, ignored_items, results_seen, frames_done);
    $display("all filter modes, register clamps, a partial widest row, heights to 8191,");
    $display("and an output hold-off that fills the queue");
    if (error_count == 0 && expected_pixels.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/wf3_pkg.sv
rtl/core/wf3_front.sv
rtl/core/wf3_queue.sv
rtl/core/wf3_back.sv
rtl/core/window_filter_3x3_stream.sv
sim/tb_window_filter_3x3_stream.sv
